@@ rtl/stack_allocator_with_markers_core_assert.svh @@
// Assertion macros for the stack allocator core.
// Included by the top level; depends on nothing else.
`ifndef STACK_ALLOCATOR_WITH_MARKERS_CORE_ASSERT_SVH
`define STACK_ALLOCATOR_WITH_MARKERS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAM_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stack allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAM_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stack allocator assertion failed");

`endif

@@ rtl/sam_pkg.sv @@
// Shared types and codes of the stack allocator core.
// Used by the controller, the datapath and the top level; no dependencies.
package sam_pkg;

	localparam int REQ_W    = 3;
	localparam int SIZE_W   = 21;
	localparam int ALIGN_W  = 13;
	localparam int SEL_W    = 7;
	localparam int STAT_W   = 3;
	localparam int ADDR_W   = 33;
	localparam int CNT_W    = 16;
	localparam int BASE_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 144;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_ALLOC       = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CAN_ALLOC   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PUSH        = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_TO      = 3'd3;
	localparam logic [REQ_W-1:0] REQ_POP         = 3'd4;
	localparam logic [REQ_W-1:0] REQ_RESET       = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RESET_PEAKS = 3'd6;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_MEM    = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_MARK  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_MARK   = 3'd4;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;
	localparam logic [STAT_W-1:0] ST_BAD_ALIGN = 3'd6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SIZE = 1'b1;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [SIZE_W-1:0]  alloc_size;
		logic [ALIGN_W-1:0] alignment;
		logic [SEL_W-1:0]   marker_sel;
	} req_t;

	// Declared from the highest bit down so that status lands in the lowest bits.
	typedef struct packed {
		logic [SEL_W-1:0]  peak_markers_out;
		logic [SIZE_W-1:0] peak_used_out;
		logic [SEL_W-1:0]  marker_count_out;
		logic [CNT_W-1:0]  alloc_count_out;
		logic [SIZE_W-1:0] free_out;
		logic [SIZE_W-1:0] used_out;
		logic [SEL_W-1:0]  marker_id;
		logic              fits;
		logic [ADDR_W-1:0] alloc_addr;
		logic [STAT_W-1:0] status;
	} res_t;

	typedef struct packed {
		logic take;
		logic exec;
	} sam_cmd_t;

endpackage

@@ rtl/stack_allocator_with_markers_core.sv @@
// Top level of the stack allocator with markers: stream ports, configuration port, assertions.
// Depends on sam_pkg, sam_ctrl, sam_dp and the assertion macro header.
//
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tuser: req_type; tdata: request arguments
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: status, address and counters
// cfg      in   cfg_we                         cfg_idx, cfg_wdata
//
// Each request is taken in the accept cycle, which reads the marker memory into a
// register; the execute state then updates the counters and loads the result
// register. A new request is accepted only once the execute state has finished.
// Reset clears the counters, peaks and configuration; the marker memory is not cleared.
// A result waiting in the output register does not block the next request; that
// request is accepted and holds in its execute cycle until the register frees.
`include "stack_allocator_with_markers_core_assert.svh"

module stack_allocator_with_markers_core #(
	parameter int MAX_MARKERS  = 64,
	parameter int HEADER_BYTES = 16,
	parameter int ARENA_BITS   = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sam_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [sam_pkg::BASE_W-1:0]          cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// alloc_size [20:0], alignment [33:21], marker_sel [40:34], zero fill above
	input  logic [sam_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// req_type [2:0]
	input  logic [sam_pkg::REQ_W-1:0]           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// status [2:0], alloc_addr [35:3], fits [36], marker_id [43:37], used_out [64:44],
	// free_out [85:65], alloc_count_out [101:86], marker_count_out [108:102],
	// peak_used_out [129:109], peak_markers_out [136:130], zero fill above
	output logic [sam_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
	import sam_pkg::*;

	req_t     req;
	res_t     res;
	sam_cmd_t cmd;

	assign req.req_type   = s_axis_tuser;
	assign req.alloc_size = s_axis_tdata[SIZE_W-1:0];
	assign req.alignment  = s_axis_tdata[SIZE_W+ALIGN_W-1:SIZE_W];
	assign req.marker_sel = s_axis_tdata[SIZE_W+ALIGN_W+SEL_W-1:SIZE_W+ALIGN_W];

	assign m_axis_tdata = OUT_TDATA_W'(res);

	sam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	sam_dp #(
		.MAX_MARKERS  (MAX_MARKERS),
		.HEADER_BYTES (HEADER_BYTES),
		.ARENA_BITS   (ARENA_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

	// A taken request occupies the execute cycle, so no request follows directly.
	`SAM_ASSERT_NEXT(a_no_back_to_back, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// A fresh result only appears after a request was taken.
	`SAM_ASSERT_IMP(a_result_follows_request, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))
	`SAM_ASSERT_IMP(a_fits_is_ok, clk, arst_n, m_axis_tvalid && res.fits, res.status == ST_OK)
	`SAM_ASSERT_IMP(a_addr_only_on_alloc, clk, arst_n, m_axis_tvalid && (res.alloc_addr != '0), (res.status == ST_OK) && (res.marker_id == '0) && !res.fits)

endmodule

@@ rtl/sam_ctrl.sv @@
// Request sequencer of the stack allocator: accept, execute, result hand-off.
// Depends on sam_pkg for the command struct.
module sam_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sam_pkg::sam_cmd_t cmd
);
	import sam_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.take  = in_valid && (state_q == S_IDLE);
	assign cmd.exec  = (state_q == S_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_EXEC: begin
					// The result register must be empty or emptying before it is reloaded.
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/sam_dp.sv @@
// Datapath of the stack allocator: counters, marker memory, alignment math and result register.
// Depends on sam_pkg; driven by the commands of sam_ctrl.
module sam_dp #(
	parameter int MAX_MARKERS  = 64,
	parameter int HEADER_BYTES = 16,
	parameter int ARENA_BITS   = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sam_pkg::sam_cmd_t                 cmd,
	input  sam_pkg::req_t                     req,
	input  logic                              cfg_we,
	input  logic [sam_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [sam_pkg::BASE_W-1:0]        cfg_wdata,
	output sam_pkg::res_t                     res
);
	import sam_pkg::*;

	localparam int DW       = $clog2(MAX_MARKERS + 1);
	localparam int AW       = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
	localparam int CW       = (DW > SEL_W) ? DW : SEL_W;
	localparam int LIM_W    = SIZE_W + 1;
	localparam int CAP_BITS = (ARENA_BITS < SIZE_W) ? ARENA_BITS : SIZE_W;
	localparam int PAD_W    = $clog2(HEADER_BYTES + (1 << (ALIGN_W - 1)));
	localparam int NEED_W   = SIZE_W + 1;
	localparam int REST_W   = SIZE_W + 3;
	localparam logic [LIM_W-1:0] ARENA_CAP = LIM_W'(1) << CAP_BITS;
	localparam logic [DW-1:0]    MAX_D     = DW'(MAX_MARKERS);

	typedef struct packed {
		logic [SIZE_W-1:0] pos;
		logic [CNT_W-1:0]  allocs;
	} mark_t;

	// Configuration and allocator state.
	logic [BASE_W-1:0] base_q;
	logic [SIZE_W-1:0] total_q;
	logic [SIZE_W-1:0] used_q;
	logic [CNT_W-1:0]  allocs_q;
	logic [DW-1:0]     depth_q;
	logic [SIZE_W-1:0] peak_used_q;
	logic [DW-1:0]     peak_mark_q;

	// Request stage, loaded when a request is taken.
	logic [REQ_W-1:0]  req_s1;
	logic              size_zero_s1;
	logic              align_ok_s1;
	logic              sel_bad_s1;
	logic              full_s1;
	logic              empty_s1;
	logic [DW-1:0]     rdepth_s1;
	logic [ADDR_W-1:0] cur_s1;
	logic [PAD_W-1:0]  pad_s1;
	logic [NEED_W-1:0] need_s1;
	logic [REST_W-1:0] avail_s1;
	mark_t             rd_s1;

	mark_t mark_mem [MAX_MARKERS];
	res_t  res_q;

	logic [LIM_W-1:0]   limit;
	logic [ALIGN_W-1:0] mask_c;
	logic [ALIGN_W-1:0] low_c;
	logic [ALIGN_W-1:0] rem_c;
	logic [PAD_W-1:0]   pad_c;
	logic [AW-1:0]      rd_addr_c;
	logic [AW-1:0]      wr_addr_c;

	logic [REST_W-1:0] rest_c;
	logic              fit_c;
	logic [SIZE_W-1:0] sum_c;
	logic [ADDR_W-1:0] addr_c;
	logic [DW-1:0]     depth_inc_c;

	logic [SIZE_W-1:0] used_nx;
	logic [CNT_W-1:0]  allocs_nx;
	logic [DW-1:0]     depth_nx;
	logic [SIZE_W-1:0] peak_used_nx;
	logic [DW-1:0]     peak_mark_nx;
	logic [SIZE_W-1:0] free_nx;
	logic [STAT_W-1:0] status_nx;
	logic [ADDR_W-1:0] addr_nx;
	logic              fits_nx;
	logic [SEL_W-1:0]  mid_nx;
	logic              push_c;

	assign limit = ({1'b0, total_q} < ARENA_CAP) ? {1'b0, total_q} : ARENA_CAP;

	// Only the low bits of the fill pointer decide the padding, as the alignment
	// divides 2^ALIGN_W.
	assign mask_c = req.alignment - ALIGN_W'(1);
	assign low_c  = base_q[ALIGN_W-1:0] + used_q[ALIGN_W-1:0] + ALIGN_W'(HEADER_BYTES);
	assign rem_c  = (ALIGN_W'(0) - low_c) & mask_c;
	assign pad_c  = PAD_W'(HEADER_BYTES) + PAD_W'(rem_c);

	assign rd_addr_c = (req.req_type == REQ_POP_TO) ? AW'(req.marker_sel - SEL_W'(1))
	                                                : AW'(depth_q - DW'(1));
	assign wr_addr_c = AW'(depth_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			total_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_BASE_ADDR:  base_q  <= cfg_wdata;
				CFG_TOTAL_SIZE: total_q <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_s1       <= req.req_type;
			size_zero_s1 <= (req.alloc_size == '0);
			align_ok_s1  <= $onehot(req.alignment);
			sel_bad_s1   <= (req.marker_sel == '0) || (CW'(req.marker_sel) > CW'(depth_q));
			full_s1      <= (depth_q >= MAX_D);
			empty_s1     <= (depth_q == '0);
			rdepth_s1    <= (req.req_type == REQ_POP_TO) ? DW'(req.marker_sel - SEL_W'(1))
			                                             : depth_q - DW'(1);
			cur_s1       <= {1'b0, base_q} + ADDR_W'(used_q);
			pad_s1       <= pad_c;
			need_s1      <= NEED_W'(req.alloc_size) + NEED_W'(pad_c);
			avail_s1     <= REST_W'(limit) - REST_W'(used_q);
		end
	end

	// Marker memory: one registered read when a request is taken, one write on a push.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rd_s1 <= mark_mem[rd_addr_c];
		end
		if (cmd.exec && push_c) begin
			mark_mem[wr_addr_c] <= '{pos: used_q, allocs: allocs_q};
		end
	end

	assign rest_c      = avail_s1 - REST_W'(need_s1);
	assign fit_c       = !rest_c[REST_W-1];
	assign sum_c       = used_q + SIZE_W'(need_s1);
	assign addr_c      = cur_s1 + ADDR_W'(pad_s1);
	assign depth_inc_c = depth_q + DW'(1);

	always_comb begin
		used_nx      = used_q;
		allocs_nx    = allocs_q;
		depth_nx     = depth_q;
		peak_used_nx = peak_used_q;
		peak_mark_nx = peak_mark_q;
		status_nx    = ST_OK;
		addr_nx      = '0;
		fits_nx      = 1'b0;
		mid_nx       = '0;
		push_c       = 1'b0;
		unique case (req_s1)
			REQ_ALLOC: begin
				if (size_zero_s1) begin
					status_nx = ST_ZERO_SIZE;
				end else if (!align_ok_s1) begin
					status_nx = ST_BAD_ALIGN;
				end else if (!fit_c) begin
					status_nx = ST_NO_MEM;
				end else begin
					used_nx = sum_c;
					if (allocs_q != '1) begin
						allocs_nx = allocs_q + CNT_W'(1);
					end
					if (sum_c > peak_used_q) begin
						peak_used_nx = sum_c;
					end
					addr_nx = addr_c;
				end
			end
			REQ_CAN_ALLOC: begin
				if (!align_ok_s1) begin
					status_nx = ST_BAD_ALIGN;
				end else begin
					fits_nx = fit_c;
				end
			end
			REQ_PUSH: begin
				if (full_s1) begin
					status_nx = ST_FULL;
				end else begin
					push_c   = 1'b1;
					depth_nx = depth_inc_c;
					if (depth_inc_c > peak_mark_q) begin
						peak_mark_nx = depth_inc_c;
					end
					mid_nx = SEL_W'(depth_inc_c);
				end
			end
			REQ_POP_TO: begin
				if (sel_bad_s1) begin
					status_nx = ST_BAD_MARK;
				end else begin
					used_nx   = rd_s1.pos;
					allocs_nx = rd_s1.allocs;
					depth_nx  = rdepth_s1;
				end
			end
			REQ_POP: begin
				if (empty_s1) begin
					status_nx = ST_NO_MARK;
				end else begin
					used_nx   = rd_s1.pos;
					allocs_nx = rd_s1.allocs;
					depth_nx  = rdepth_s1;
				end
			end
			REQ_RESET: begin
				used_nx   = '0;
				allocs_nx = '0;
				depth_nx  = '0;
			end
			REQ_RESET_PEAKS: begin
				peak_used_nx = used_q;
				peak_mark_nx = depth_q;
			end
			default: ;
		endcase
		free_nx = (LIM_W'(used_nx) < limit) ? SIZE_W'(limit - LIM_W'(used_nx)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			allocs_q    <= '0;
			depth_q     <= '0;
			peak_used_q <= '0;
			peak_mark_q <= '0;
		end else if (cmd.exec) begin
			used_q      <= used_nx;
			allocs_q    <= allocs_nx;
			depth_q     <= depth_nx;
			peak_used_q <= peak_used_nx;
			peak_mark_q <= peak_mark_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q.status           <= status_nx;
			res_q.alloc_addr       <= addr_nx;
			res_q.fits             <= fits_nx;
			res_q.marker_id        <= mid_nx;
			res_q.used_out         <= used_nx;
			res_q.free_out         <= free_nx;
			res_q.alloc_count_out  <= allocs_nx;
			res_q.marker_count_out <= SEL_W'(depth_nx);
			res_q.peak_used_out    <= peak_used_nx;
			res_q.peak_markers_out <= SEL_W'(peak_mark_nx);
		end
	end

	assign res = res_q;

endmodule
